FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// clocked implication with asynchronous reset disable
`define CHK_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/sha_pkg.sv
// sha-256 constants, types and rotate function
// no dependencies
package sha_pkg;
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_POS = 6'd56;

  typedef logic [31:0] word_t;
  typedef word_t state_t [8];

  typedef struct packed {
    logic load;
    logic run;
    logic [5:0] rnd;
  } round_ctl_t;

  function automatic word_t ror(input word_t x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction
endpackage

FILE: rtl/sha_if.sv
// valid/ready channel interfaces for the hasher
// depends on nothing
interface sha_in_if;
  logic valid;
  logic ready;
  logic [7:0] data_byte;
  logic has_byte;
  logic end_of_message;
  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic valid;
  logic ready;
  logic [31:0] digest_word;
  logic [2:0] word_index;
  logic last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/sha_round.sv
// shared round unit: working variables and rolling message schedule
// depends on sha_pkg
module sha_round import sha_pkg::*; (
  input  logic         clk_i,
  input  round_ctl_t   ctl_i,
  input  word_t        blk_word_i,
  input  state_t       chain_i,
  output state_t       work_o
);
  state_t v_q;
  word_t w_q [16];
  word_t w_new, w_cur, t1, t2, w2, w15, s0, s1;

  always_comb begin
    w2 = w_q[14];
    w15 = w_q[1];
    s1 = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
    s0 = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
    w_new = s1 + w_q[9] + s0 + w_q[0];
    w_cur = (ctl_i.rnd < 6'd16) ? w_q[0] : w_new;
    t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25)) +
         ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + ROUND_K[ctl_i.rnd] + w_cur;
    t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // window shifts: w_q[0] is the word for rounds 0-15, w_new for the later rounds
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= blk_word_i;
      v_q <= chain_i;
    end else if (ctl_i.run) begin
      if (ctl_i.rnd < 6'd16) begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_q[0];
      end else begin
        for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
        w_q[15] <= w_new;
      end
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  assign work_o = v_q;
endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
// top level: byte collection, padding sequencer, chaining value and digest out
// depends on sha_pkg, sha_if, sha_round
// At most one message byte is taken per accepted word while the 64-byte block is filling; the
// word that completes a block is followed by the load phase, the round phase of the single
// shared round unit and the chaining update (not ready meanwhile). An end-of-message word
// adds padding at one byte a cycle from the fill level to 64, one or two compressions, and eight
// digest words; the next message is taken once the last digest word has gone.
module sha256_byte_stream_hasher import sha_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);
  localparam logic [2:0] S_IDLE = 3'd0, S_PAD = 3'd1, S_LOAD = 3'd2, S_RUN = 3'd3,
                         S_ADD = 3'd4, S_OUT = 3'd5;

  logic [2:0] st_q, st_d;
  logic [63:0] cnt_q;
  logic [5:0] ptr_q;
  logic [5:0] rnd_q;
  logic fin_q, len_q, blk_q;
  logic [2:0] oi_q;
  word_t buf_q [16];
  state_t h_q, work;
  word_t blk_word;
  logic [63:0] bits;
  logic [7:0] pad_b;
  round_ctl_t ctl;
  logic acc, wr_en;
  logic [7:0] wr_b;
  logic [5:0] wr_addr;

  assign acc = in_i.valid && in_i.ready;
  assign in_i.ready = (st_q == S_IDLE);
  assign bits = {cnt_q[60:0], 3'b000};

  always_comb begin
    if (ptr_q >= LEN_POS && len_q) pad_b = bits[{~ptr_q[2:0], 3'b000} +: 8];
    else if (ptr_q == cnt_q[5:0]) pad_b = PAD_BYTE;
    else pad_b = 8'h00;
  end

  assign blk_word = buf_q[rnd_q[3:0]];
  assign ctl = '{load: st_q == S_LOAD, run: st_q == S_RUN, rnd: rnd_q};

  sha_round u_round (.clk_i, .ctl_i(ctl), .blk_word_i(blk_word), .chain_i(h_q), .work_o(work));

  assign wr_en = (acc && in_i.has_byte) || st_q == S_PAD;
  assign wr_b = (st_q == S_PAD) ? pad_b : in_i.data_byte;
  assign wr_addr = (st_q == S_PAD) ? ptr_q : cnt_q[5:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) buf_q[wr_addr[5:2]][{~wr_addr[1:0], 3'b000} +: 8] <= wr_b;
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (acc) begin
        if (in_i.has_byte && cnt_q[5:0] == 6'd63) st_d = S_LOAD;
        else if (in_i.end_of_message) st_d = S_PAD;
      end
      S_PAD:  if (ptr_q == 6'd63) st_d = S_LOAD;
      S_LOAD: if (rnd_q == 6'd15) st_d = S_RUN;
      S_RUN:  if (rnd_q == 6'd63) st_d = S_ADD;
      S_ADD:  st_d = !fin_q ? S_IDLE : ((blk_q || !len_q) ? S_PAD : S_OUT);
      S_OUT:  if (out_o.ready && oi_q == 3'd7) st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      ptr_q <= '0;
      rnd_q <= '0;
      fin_q <= 1'b0;
      len_q <= 1'b0;
      blk_q <= 1'b0;
      oi_q <= '0;
      h_q <= IV;
    end else begin
      st_q <= st_d;
      case (st_q)
        S_IDLE: if (acc) begin
          fin_q <= in_i.end_of_message;
          blk_q <= in_i.has_byte && cnt_q[5:0] == 6'd63;
          rnd_q <= '0;
          if (in_i.has_byte) begin
            cnt_q <= cnt_q + 64'd1;
            ptr_q <= cnt_q[5:0] + 6'd1;
          end else ptr_q <= cnt_q[5:0];
          // length goes in this block if 0x80 lands before the length field
          len_q <= (in_i.has_byte ? cnt_q[5:0] + 6'd1 : cnt_q[5:0]) < LEN_POS;
        end
        S_PAD: ptr_q <= ptr_q + 6'd1;
        S_LOAD: rnd_q <= (rnd_q == 6'd15) ? 6'd0 : rnd_q + 6'd1;
        S_RUN: rnd_q <= rnd_q + 6'd1;
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + work[i];
          rnd_q <= '0;
          oi_q <= '0;
          blk_q <= 1'b0;
          if (fin_q && !len_q) begin
            // second pass: zeros then length, 0x80 already placed
            len_q <= 1'b1;
            ptr_q <= '0;
          end
        end
        S_OUT: if (out_o.ready) begin
          oi_q <= oi_q + 3'd1;
          if (oi_q == 3'd7) begin
            h_q <= IV;
            cnt_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_o.valid = (st_q == S_OUT);
  assign out_o.digest_word = h_q[oi_q];
  assign out_o.word_index = oi_q;
  assign out_o.last_word = (oi_q == 3'd7);
endmodule

FILE: rtl/sha_checker.sv
// port-level checks for the hasher, bound to the top level
// depends on assert_macros.svh, sha_if
`include "assert_macros.svh"
module sha_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid, in_ready, out_valid, out_ready, last_word,
  input logic [2:0] word_index
);
  `CHK_IMPL(a_no_overlap, clk_i, rst_ni, out_valid, !in_ready)
  `CHK_IMPL(a_last_idx, clk_i, rst_ni, out_valid, last_word == (word_index == 3'd7))
  `CHK_NEXT(a_idx_step, clk_i, rst_ni, out_valid && out_ready && !last_word, out_valid && word_index == $past(word_index) + 3'd1)
  `CHK_NEXT(a_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(word_index))
endmodule

bind sha256_byte_stream_hasher sha_checker u_chk (
  .clk_i, .rst_ni, .in_valid(in_i.valid), .in_ready(in_i.ready), .out_valid(out_o.valid),
  .out_ready(out_o.ready), .last_word(out_o.last_word), .word_index(out_o.word_index));
